// ----- src/chse_pkg.sv -----
// Shared types and constants for the cubic Hermite spline evaluator.
// Used by the channel interfaces and the top level; depends on nothing.
package chse_pkg;

    // Fixed field widths of the channels
    localparam int PARAM_W = 24;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int DATA_W  = 32;

    // Operation codes
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Evaluation sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUBE,
        ST_BASIS,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } chse_state_t;

endpackage

// ----- src/chse_if.sv -----
// Valid/ready channel interfaces for the spline evaluator request and result.
// Depends on chse_pkg for field widths.
interface chse_req_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic        [chse_pkg::PARAM_W-1:0] position_param;
    logic        [chse_pkg::INDEX_W-1:0] entry_index;
    logic signed [chse_pkg::DATA_W-1:0]  knot_x;
    logic signed [chse_pkg::DATA_W-1:0]  knot_y;
    logic signed [chse_pkg::DATA_W-1:0]  tangent_x;
    logic signed [chse_pkg::DATA_W-1:0]  tangent_y;

    modport source (
        output valid, operation, position_param, entry_index,
               knot_x, knot_y, tangent_x, tangent_y,
        input  ready
    );
    modport sink (
        input  valid, operation, position_param, entry_index,
               knot_x, knot_y, tangent_x, tangent_y,
        output ready
    );
endinterface

interface chse_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               in_range;
    logic signed [chse_pkg::DATA_W-1:0] out_x;
    logic signed [chse_pkg::DATA_W-1:0] out_y;
    logic signed [chse_pkg::DATA_W-1:0] out_dx;
    logic signed [chse_pkg::DATA_W-1:0] out_dy;

    modport source (
        output valid, in_range, out_x, out_y, out_dx, out_dy,
        input  ready
    );
    modport sink (
        input  valid, in_range, out_x, out_y, out_dx, out_dy,
        output ready
    );
endinterface

// ----- src/cubic_hermite_spline_eval.sv -----
// Cubic Hermite spline evaluator over a knot table held in two synchronous memories.
// Depends on chse_pkg and the chse_req_if / chse_rsp_if channel interfaces.
//
// The block holds up to MAX_POINTS two-dimensional knots (position and tangent,
// signed Q16.16) in a position memory and a tangent memory, each with one write
// port and two registered read ports. A load transfer writes one knot;
// indexes at or above MAX_POINTS are dropped. An evaluate transfer
// reads knots seg and seg+1 in the cycle of the transfer, then a six-state
// sequencer forms t^2, t^3, the four Hermite basis weights, eight 51-bit
// products and their rounded, saturated sums. An evaluate occupies the block
// until its result enters the output register, and the next request is
// taken the cycle after that; the output register lets a finished
// result wait while the next request is taken. point_count values above
// MAX_POINTS act as MAX_POINTS, and a count of zero makes every evaluate out
// of range. Knots never loaded read as undefined. There is no clearing pass.
module cubic_hermite_spline_eval #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [chse_pkg::COUNT_W-1:0] cfg_wr_data,
    chse_req_if.sink                     req,
    chse_rsp_if.source                   rsp
);

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int UW      = chse_pkg::PARAM_W + 1;   // segment / count compare width
    localparam int DW      = chse_pkg::DATA_W;
    localparam int EW      = FRAC_BITS + 4;           // basis intermediate width
    localparam int HW      = FRAC_BITS + 3;           // basis weight width
    localparam int PW      = HW + DW;                 // product width
    localparam int SW      = PW + 2;                  // sum of four products
    localparam int unsigned HALF  = 1 << (FRAC_BITS - 1);
    localparam int unsigned ONE_Q = 1 << FRAC_BITS;

    // Knot memories: position {y, x}, tangent {dy, dx}
    logic [2*DW-1:0] pos_mem [MAX_POINTS];
    logic [2*DW-1:0] tan_mem [MAX_POINTS];

    chse_pkg::chse_state_t state_reg, state_next;

    logic [chse_pkg::COUNT_W-1:0] point_count_reg;
    logic                         out_valid_reg, out_valid_next;

    // Sequencer outputs
    logic req_accept, eval_start, load_wr, out_load;

    // Request decode
    logic [UW-1:0]        seg_w, cnt_w;
    logic [FRAC_BITS-1:0] t_in;
    logic [AW-1:0]        rd_addr0, rd_addr1, wr_addr;
    logic                 range_ok;

    // Datapath registers
    logic [2*DW-1:0]         pos0_reg, pos1_reg, tan0_reg, tan1_reg;
    logic                    in_range_reg, whole_reg;
    logic [FRAC_BITS-1:0]    t_reg, t2_reg;
    logic [2*FRAC_BITS-1:0]  sq_reg, cube_reg;
    logic signed [HW-1:0]    h00_reg, h10_reg, h01_reg, h11_reg;
    logic signed [PW-1:0]    px0_reg, px1_reg, px2_reg, px3_reg;
    logic signed [PW-1:0]    py0_reg, py1_reg, py2_reg, py3_reg;
    logic signed [SW-1:0]    xa_reg, xb_reg, ya_reg, yb_reg;

    // Result register
    logic                 res_in_range_reg;
    logic signed [DW-1:0] res_x_reg, res_y_reg, res_dx_reg, res_dy_reg;

    // Stage logic
    logic [2*FRAC_BITS:0] sq_rnd, cube_rnd;
    logic [FRAC_BITS-1:0] t2_c, t3_c;
    logic signed [EW-1:0] st_e, s2_e, s3_e, one_e;
    logic signed [EW-1:0] h00_e, h10_e, h01_e, h11_e;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [DW-1:0] fx, fy;

    // Round half up to Q16.16 and saturate to 32 bits
    function automatic logic signed [DW-1:0] round_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] q;
        logic signed [DW-1:0] r;
        v = s + SW'(HALF);
        q = v >>> FRAC_BITS;
        if (q[SW-1:DW-1] == '0 || q[SW-1:DW-1] == '1)
        begin
            r = q[DW-1:0];
        end
        else if (q[SW-1])
        begin
            r = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            point_count_reg <= cfg_wr_data;
        end
    end

    // Request decode: segment, fraction, clamped count, range check
    always_comb
    begin
        seg_w = UW'(req.position_param) >> FRAC_BITS;
        t_in  = req.position_param[FRAC_BITS-1:0];
        cnt_w = UW'(point_count_reg);
        if (cnt_w > UW'(MAX_POINTS))
        begin
            cnt_w = UW'(MAX_POINTS);
        end
        range_ok = (cnt_w != '0) && (seg_w < cnt_w)
                   && !((seg_w + 1'b1 == cnt_w) && (t_in != '0));
        rd_addr0 = AW'(seg_w);
        rd_addr1 = rd_addr0 + 1'b1;
        wr_addr  = AW'(req.entry_index);
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chse_pkg::ST_IDLE:
            begin
                if (eval_start)
                begin
                    state_next = chse_pkg::ST_CUBE;
                end
            end
            chse_pkg::ST_CUBE:  state_next = chse_pkg::ST_BASIS;
            chse_pkg::ST_BASIS: state_next = chse_pkg::ST_MUL;
            chse_pkg::ST_MUL:   state_next = chse_pkg::ST_SUM;
            chse_pkg::ST_SUM:   state_next = chse_pkg::ST_DONE;
            chse_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = chse_pkg::ST_IDLE;
                end
            end
            default: state_next = chse_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req.ready  = (state_reg == chse_pkg::ST_IDLE);
        req_accept = req.valid && req.ready;
        eval_start = req_accept && (req.operation == chse_pkg::OP_EVAL);
        load_wr    = req_accept && (req.operation == chse_pkg::OP_LOAD)
                     && (32'(req.entry_index) < MAX_POINTS);
        out_load   = (state_reg == chse_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chse_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Knot memory write port
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            pos_mem[wr_addr] <= {req.knot_y, req.knot_x};
            tan_mem[wr_addr] <= {req.tangent_y, req.tangent_x};
        end
    end

    // Knot memory read ports, registered; data holds until the next evaluate
    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            pos0_reg <= pos_mem[rd_addr0];
            pos1_reg <= pos_mem[rd_addr1];
            tan0_reg <= tan_mem[rd_addr0];
            tan1_reg <= tan_mem[rd_addr1];
        end
    end

    // Transfer stage: fraction, t*t, range flags
    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            t_reg        <= t_in;
            sq_reg       <= t_in * t_in;
            in_range_reg <= range_ok;
            whole_reg    <= (t_in == '0);
        end
    end

    // t2 rounding, t3 rounding and basis weights
    always_comb
    begin
        sq_rnd   = {1'b0, sq_reg} + (2*FRAC_BITS+1)'(HALF);
        t2_c     = sq_rnd[2*FRAC_BITS-1:FRAC_BITS];
        cube_rnd = {1'b0, cube_reg} + (2*FRAC_BITS+1)'(HALF);
        t3_c     = cube_rnd[2*FRAC_BITS-1:FRAC_BITS];
        st_e     = EW'(t_reg);
        s2_e     = EW'(t2_reg);
        s3_e     = EW'(t3_c);
        one_e    = EW'(ONE_Q);
        h00_e    = one_e - ((s2_e <<< 1) + s2_e) + (s3_e <<< 1);
        h10_e    = st_e - (s2_e <<< 1) + s3_e;
        h01_e    = ((s2_e <<< 1) + s2_e) - (s3_e <<< 1);
        h11_e    = s3_e - s2_e;
    end

    // Cube stage
    always_ff @(posedge clk)
    begin
        if (state_reg == chse_pkg::ST_CUBE)
        begin
            t2_reg   <= t2_c;
            cube_reg <= t2_c * t_reg;
        end
    end

    // Basis stage
    always_ff @(posedge clk)
    begin
        if (state_reg == chse_pkg::ST_BASIS)
        begin
            h00_reg <= h00_e[HW-1:0];
            h10_reg <= h10_e[HW-1:0];
            h01_reg <= h01_e[HW-1:0];
            h11_reg <= h11_e[HW-1:0];
        end
    end

    // Product stage: weight times knot component
    always_ff @(posedge clk)
    begin
        if (state_reg == chse_pkg::ST_MUL)
        begin
            px0_reg <= h00_reg * $signed(pos0_reg[DW-1:0]);
            px1_reg <= h10_reg * $signed(tan0_reg[DW-1:0]);
            px2_reg <= h01_reg * $signed(pos1_reg[DW-1:0]);
            px3_reg <= h11_reg * $signed(tan1_reg[DW-1:0]);
            py0_reg <= h00_reg * $signed(pos0_reg[2*DW-1:DW]);
            py1_reg <= h10_reg * $signed(tan0_reg[2*DW-1:DW]);
            py2_reg <= h01_reg * $signed(pos1_reg[2*DW-1:DW]);
            py3_reg <= h11_reg * $signed(tan1_reg[2*DW-1:DW]);
        end
    end

    // Pairwise sums
    always_ff @(posedge clk)
    begin
        if (state_reg == chse_pkg::ST_SUM)
        begin
            xa_reg <= SW'(px0_reg) + SW'(px1_reg);
            xb_reg <= SW'(px2_reg) + SW'(px3_reg);
            ya_reg <= SW'(py0_reg) + SW'(py1_reg);
            yb_reg <= SW'(py2_reg) + SW'(py3_reg);
        end
    end

    // Final sum, round and saturate
    always_comb
    begin
        sum_x = xa_reg + xb_reg;
        sum_y = ya_reg + yb_reg;
        fx    = round_sat(sum_x);
        fy    = round_sat(sum_y);
    end

    // Result register: out of range, whole parameter or blended position
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_in_range_reg <= in_range_reg;
            if (!in_range_reg)
            begin
                res_x_reg  <= '0;
                res_y_reg  <= '0;
                res_dx_reg <= '0;
                res_dy_reg <= '0;
            end
            else if (whole_reg)
            begin
                res_x_reg  <= pos0_reg[DW-1:0];
                res_y_reg  <= pos0_reg[2*DW-1:DW];
                res_dx_reg <= tan0_reg[DW-1:0];
                res_dy_reg <= tan0_reg[2*DW-1:DW];
            end
            else
            begin
                res_x_reg  <= fx;
                res_y_reg  <= fy;
                res_dx_reg <= '0;
                res_dy_reg <= '0;
            end
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.in_range = res_in_range_reg;
    assign rsp.out_x    = res_x_reg;
    assign rsp.out_y    = res_y_reg;
    assign rsp.out_dx   = res_dx_reg;
    assign rsp.out_dy   = res_dy_reg;

    // An evaluate transfer starts the sequencer
    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        eval_start |=> state_reg == chse_pkg::ST_CUBE)
        else $error("evaluate transfer did not start the sequencer");

    // A load transfer leaves the block ready
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req.operation == chse_pkg::OP_LOAD)
        |=> state_reg == chse_pkg::ST_IDLE)
        else $error("load transfer disturbed the sequencer");

    // A finished evaluation lands in the result register and frees the block
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (rsp.valid && state_reg == chse_pkg::ST_IDLE))
        else $error("finished result not presented");

    // Out of range results carry all-zero fields
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.in_range)
        |-> (rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_dx == '0 && rsp.out_dy == '0))
        else $error("out of range result has nonzero fields");

endmodule
